// ===== rtl/queued_pipelined_bus_master_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the queued pipelined bus master
// Shared assertion shorthands; they expect clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef QUEUED_PIPELINED_BUS_MASTER_TOP_MACROS_SVH
`define QUEUED_PIPELINED_BUS_MASTER_TOP_MACROS_SVH

// Same-cycle implication.
`define QPBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QPBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// qpbm_pkg
// Shared defaults and control/status types of the queued pipelined bus master.
// ----------------------------------------------------------------------------
package qpbm_pkg;

    localparam int DEF_ADDR_WIDTH    = 32;
    localparam int DEF_DATA_WIDTH    = 32;
    localparam int DEF_CMD_DEPTH     = 16;
    localparam int DEF_PENDING_DEPTH = 16;
    localparam int DEF_RX_DEPTH      = 16;
    localparam int DEF_FIFO_WIDTH    = 1;

    // Queue update request for one beat.
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    // Output buffer status toward the control logic.
    typedef struct packed {
        logic room;      // fewer than two results held
        logic can_take;  // a result can be written at this edge
    } skid_stat_t;

endpackage

// ===== rtl/qpbm_ifs.sv =====
// ----------------------------------------------------------------------------
// qpbm interfaces
// Valid/ready channels for the per-edge input beat and the result beat.
// ----------------------------------------------------------------------------
interface qpbm_item_if #(
    parameter int ADDR_WIDTH = qpbm_pkg::DEF_ADDR_WIDTH,
    parameter int DATA_WIDTH = qpbm_pkg::DEF_DATA_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic                  cmd_valid;
    logic                  cmd_write;
    logic [ADDR_WIDTH-1:0] cmd_addr;
    logic [DATA_WIDTH-1:0] cmd_wdata;
    logic                  bus_ack;
    logic                  bus_stall;
    logic [DATA_WIDTH-1:0] bus_rdata;
    logic                  rx_pop;

    modport source (
        output valid, cmd_valid, cmd_write, cmd_addr, cmd_wdata,
               bus_ack, bus_stall, bus_rdata, rx_pop,
        input  ready
    );
    modport sink (
        input  valid, cmd_valid, cmd_write, cmd_addr, cmd_wdata,
               bus_ack, bus_stall, bus_rdata, rx_pop,
        output ready
    );
endinterface

interface qpbm_result_if #(
    parameter int ADDR_WIDTH = qpbm_pkg::DEF_ADDR_WIDTH,
    parameter int DATA_WIDTH = qpbm_pkg::DEF_DATA_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic                  bus_cyc;
    logic                  bus_stb;
    logic                  bus_we;
    logic [ADDR_WIDTH-1:0] bus_addr;
    logic [DATA_WIDTH-1:0] bus_wdata;
    logic                  rx_valid;
    logic [DATA_WIDTH-1:0] rx_word;
    logic                  cmd_dropped;
    logic                  rx_dropped;

    modport source (
        output valid, bus_cyc, bus_stb, bus_we, bus_addr, bus_wdata,
               rx_valid, rx_word, cmd_dropped, rx_dropped,
        input  ready
    );
    modport sink (
        input  valid, bus_cyc, bus_stb, bus_we, bus_addr, bus_wdata,
               rx_valid, rx_word, cmd_dropped, rx_dropped,
        output ready
    );
endinterface

// ===== rtl/queued_pipelined_bus_master_top.sv =====
// ----------------------------------------------------------------------------
// queued_pipelined_bus_master_top
// Pipelined bus master with command, outstanding-access and receive queues.
// ----------------------------------------------------------------------------
// Each input beat is one bus clock edge: it carries the slave response, an
// optional new command and an optional receive pop, and it produces exactly
// one result beat holding the bus outputs and queue status after that edge.
// One input beat is taken every clock cycle unless input stalls; the result
// is held in the state registers and then passes through a two-entry output
// buffer. Input stalls only when that buffer is full and a result is still
// waiting to enter it. The three queues live in synchronous memories with a
// registered read; each keeps its head entry prefetched in a register and
// forwards a write that lands on the entry being fetched, which is what
// allows a new beat in every cycle. The queue stores need no clearing after
// reset, so the block is ready at once.
module queued_pipelined_bus_master_top #(
    parameter int ADDR_WIDTH    = qpbm_pkg::DEF_ADDR_WIDTH,
    parameter int DATA_WIDTH    = qpbm_pkg::DEF_DATA_WIDTH,
    parameter int CMD_DEPTH     = qpbm_pkg::DEF_CMD_DEPTH,
    parameter int PENDING_DEPTH = qpbm_pkg::DEF_PENDING_DEPTH,
    parameter int RX_DEPTH      = qpbm_pkg::DEF_RX_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    qpbm_item_if.sink      item,
    qpbm_result_if.source  result
);

    `include "queued_pipelined_bus_master_top_macros.svh"

    localparam int CMD_CW  = $clog2(CMD_DEPTH + 1);
    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
    localparam int RX_CW   = $clog2(RX_DEPTH + 1);

    typedef struct packed {
        logic                  we;
        logic [ADDR_WIDTH-1:0] addr;
        logic [DATA_WIDTH-1:0] wdata;
    } cmd_entry_t;

    typedef struct packed {
        logic                  bus_cyc;
        logic                  bus_stb;
        logic                  bus_we;
        logic [ADDR_WIDTH-1:0] bus_addr;
        logic [DATA_WIDTH-1:0] bus_wdata;
        logic                  rx_valid;
        logic [DATA_WIDTH-1:0] rx_word;
        logic                  cmd_dropped;
        logic                  rx_dropped;
    } res_t;

    // Bus and flag registers.
    logic                  cyc_reg, cyc_next;
    logic                  stb_reg, stb_next;
    logic                  we_reg, we_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [DATA_WIDTH-1:0] wdata_reg, wdata_next;
    logic                  cmd_drop_reg, cmd_drop_next;
    logic                  rx_drop_reg, rx_drop_next;
    logic                  res_pending_reg, res_pending_next;

    // Queue side.
    qpbm_pkg::fifo_ctl_t   cmd_ctl, pend_ctl, rx_ctl;
    cmd_entry_t            cmd_push_word, cmd_head_word;
    logic [CMD_CW-1:0]     cmd_count;
    logic [PEND_CW-1:0]    pend_count, pend_cnt_a, pend_cnt_c;
    logic [0:0]            pend_push_kind, pend_head_kind;
    logic [RX_CW-1:0]      rx_count;
    logic [DATA_WIDTH-1:0] rx_head_word;

    // Per-beat decisions.
    logic                  item_acc;
    logic                  in_ready;
    logic                  rx_pop_eff;
    logic                  accept_stb;
    logic                  stb_a, stb_b, cyc_b;
    logic                  issue;
    logic                  ack_take;
    logic                  head_is_write;
    logic                  is_read;
    logic                  rx_full_after_pop;
    logic                  rx_push, rx_drop;
    logic                  cmd_push, cmd_drop;

    // Result path.
    qpbm_pkg::skid_stat_t  skid_stat;
    logic                  res_cap;
    res_t                  res_word, res_out;

    assign item_acc   = item.valid && in_ready;
    assign item.ready = in_ready;

    always_comb
    begin
        rx_pop_eff = item.rx_pop && (rx_count != '0);

        // Strobe taken by the slave: it becomes outstanding.
        accept_stb = cyc_reg && stb_reg && !item.bus_stall
                     && (pend_count != PEND_CW'(PENDING_DEPTH));
        pend_cnt_a = pend_count + PEND_CW'(accept_stb);
        stb_a      = stb_reg && !accept_stb;

        issue = !stb_a && (cmd_count != '0) && (pend_cnt_a < PEND_CW'(PENDING_DEPTH));
        cyc_b = cyc_reg || issue;
        stb_b = stb_a || issue;

        // With nothing queued before, an acknowledge retires the access that
        // was accepted at this same edge.
        ack_take      = cyc_b && item.bus_ack && (pend_cnt_a != '0);
        head_is_write = (pend_count == '0) ? we_reg : pend_head_kind[0];
        is_read       = ack_take && !head_is_write;
        pend_cnt_c    = pend_cnt_a - PEND_CW'(ack_take);

        rx_full_after_pop = (rx_count == RX_CW'(RX_DEPTH)) && !rx_pop_eff;
        rx_push = is_read && !rx_full_after_pop;
        rx_drop = is_read && rx_full_after_pop;

        // The issued command frees its slot before the new one is appended.
        cmd_push = item.cmd_valid && ((cmd_count != CMD_CW'(CMD_DEPTH)) || issue);
        cmd_drop = item.cmd_valid && !cmd_push;

        cmd_push_word.we    = item.cmd_write;
        cmd_push_word.addr  = item.cmd_addr;
        cmd_push_word.wdata = item.cmd_write ? item.cmd_wdata : '0;
        pend_push_kind      = we_reg;

        cmd_ctl.push  = item_acc && cmd_push;
        cmd_ctl.pop   = item_acc && issue;
        pend_ctl.push = item_acc && accept_stb;
        pend_ctl.pop  = item_acc && ack_take;
        rx_ctl.push   = item_acc && rx_push;
        rx_ctl.pop    = item_acc && rx_pop_eff;

        cyc_next      = cyc_reg;
        stb_next      = stb_reg;
        we_next       = we_reg;
        addr_next     = addr_reg;
        wdata_next    = wdata_reg;
        cmd_drop_next = cmd_drop_reg;
        rx_drop_next  = rx_drop_reg;
        if (item_acc)
        begin
            cyc_next      = cyc_b && !((pend_cnt_c == '0) && !stb_b);
            stb_next      = stb_b;
            cmd_drop_next = cmd_drop;
            rx_drop_next  = rx_drop;
            if (issue)
            begin
                we_next    = cmd_head_word.we;
                addr_next  = cmd_head_word.addr;
                wdata_next = cmd_head_word.wdata;
            end
            else if (accept_stb)
            begin
                we_next = 1'b0;
            end
        end

        // The result of the last beat sits in the state until it moves into
        // the output buffer; a new beat is taken only if it can move now.
        in_ready         = !res_pending_reg || skid_stat.room;
        res_cap          = res_pending_reg && skid_stat.can_take;
        res_pending_next = item_acc || (res_pending_reg && !res_cap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg         <= 1'b0;
            stb_reg         <= 1'b0;
            we_reg          <= 1'b0;
            addr_reg        <= '0;
            wdata_reg       <= '0;
            cmd_drop_reg    <= 1'b0;
            rx_drop_reg     <= 1'b0;
            res_pending_reg <= 1'b0;
        end
        else
        begin
            cyc_reg         <= cyc_next;
            stb_reg         <= stb_next;
            we_reg          <= we_next;
            addr_reg        <= addr_next;
            wdata_reg       <= wdata_next;
            cmd_drop_reg    <= cmd_drop_next;
            rx_drop_reg     <= rx_drop_next;
            res_pending_reg <= res_pending_next;
        end
    end

    qpbm_fifo #(
        .WIDTH ($bits(cmd_entry_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cmd_ctl),
        .push_data (cmd_push_word),
        .count     (cmd_count),
        .head_data (cmd_head_word)
    );

    qpbm_fifo #(
        .WIDTH (1),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pend_ctl),
        .push_data (pend_push_kind),
        .count     (pend_count),
        .head_data (pend_head_kind)
    );

    qpbm_fifo #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (RX_DEPTH)
    ) u_rx_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rx_ctl),
        .push_data (item.bus_rdata),
        .count     (rx_count),
        .head_data (rx_head_word)
    );

    always_comb
    begin
        res_word.bus_cyc     = cyc_reg;
        res_word.bus_stb     = stb_reg;
        res_word.bus_we      = stb_reg && we_reg;
        res_word.bus_addr    = stb_reg ? addr_reg : '0;
        res_word.bus_wdata   = stb_reg ? wdata_reg : '0;
        res_word.rx_valid    = (rx_count != '0);
        res_word.rx_word     = (rx_count != '0) ? rx_head_word : '0;
        res_word.cmd_dropped = cmd_drop_reg;
        res_word.rx_dropped  = rx_drop_reg;
    end

    qpbm_skid #(
        .WIDTH ($bits(res_t))
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_cap),
        .push_data (res_word),
        .stat      (skid_stat),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res_out)
    );

    assign result.bus_cyc     = res_out.bus_cyc;
    assign result.bus_stb     = res_out.bus_stb;
    assign result.bus_we      = res_out.bus_we;
    assign result.bus_addr    = res_out.bus_addr;
    assign result.bus_wdata   = res_out.bus_wdata;
    assign result.rx_valid    = res_out.rx_valid;
    assign result.rx_word     = res_out.rx_word;
    assign result.cmd_dropped = res_out.cmd_dropped;
    assign result.rx_dropped  = res_out.rx_dropped;

    `QPBM_ASSERT_IMP(a_idle_bus_empty, !cyc_reg, (pend_count == '0) && !stb_reg,
        "bus cycle ended with accesses outstanding or a strobe presented")

    `QPBM_ASSERT_IMP(a_result_not_lost, item_acc && res_pending_reg, res_cap,
        "new beat taken while the previous result could not be buffered")

    `QPBM_ASSERT_NXT(a_read_stored, item_acc && rx_push, rx_count != '0,
        "acknowledged read word missing from the receive queue")

endmodule

// ===== rtl/qpbm_fifo.sv =====
// ----------------------------------------------------------------------------
// qpbm_fifo
// Circular queue in a synchronous memory with a prefetched, registered head.
// ----------------------------------------------------------------------------
module qpbm_fifo #(
    parameter int WIDTH = qpbm_pkg::DEF_FIFO_WIDTH,
    parameter int DEPTH = qpbm_pkg::DEF_CMD_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qpbm_pkg::fifo_ctl_t        ctl,
    input  logic [WIDTH-1:0]           push_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [WIDTH-1:0]           head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];

    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [WIDTH-1:0] head_data_reg;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
        wrap_inc = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    always_comb
    begin
        head_next  = ctl.pop  ? wrap_inc(head_reg) : head_reg;
        tail_next  = ctl.push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg + CW'(ctl.push) - CW'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The read port always fetches the entry that will be the head after this
    // edge; a write to that same entry is forwarded past the memory.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctl.push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign count     = count_reg;
    assign head_data = head_data_reg;

endmodule

// ===== rtl/qpbm_skid.sv =====
// ----------------------------------------------------------------------------
// qpbm_skid
// Two-entry result buffer that decouples result beats from input beats.
// ----------------------------------------------------------------------------
module qpbm_skid #(
    parameter int WIDTH = qpbm_pkg::DEF_FIFO_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    output qpbm_pkg::skid_stat_t   stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WIDTH-1:0]       out_data
);

    logic [1:0]       cnt_reg, cnt_next;
    logic [WIDTH-1:0] slot0_reg;
    logic [WIDTH-1:0] slot1_reg;
    logic             pop;

    assign pop           = out_valid && out_ready;
    assign out_valid     = (cnt_reg != 2'd0);
    assign out_data      = slot0_reg;
    assign stat.room     = (cnt_reg != 2'd2);
    assign stat.can_take = (cnt_reg != 2'd2) || pop;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case ({push, pop})
            2'b01:
            begin
                slot0_reg <= slot1_reg;
            end
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    slot0_reg <= push_data;
                end
                else
                begin
                    slot1_reg <= push_data;
                end
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    slot0_reg <= push_data;
                end
                else
                begin
                    slot0_reg <= slot1_reg;
                    slot1_reg <= push_data;
                end
            end
            default:
            begin
                slot0_reg <= slot0_reg;
            end
        endcase
    end

endmodule

// ===== sim/tb_queued_pipelined_bus_master_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_queued_pipelined_bus_master_top
// Self-checking bench for the queued pipelined bus master. Every input beat
// stands for one bus clock edge; a predictor in the scoreboard tracks the
// command, outstanding-access and receive queues and the registered bus
// signals, and every result beat is compared field by field. A short directed
// opening is followed by random traffic in phases that mix, flood or drain the
// queues, with random gaps on both channels outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_queued_pipelined_bus_master_top;

    localparam int AW            = qpbm_pkg::DEF_ADDR_WIDTH;
    localparam int DW            = qpbm_pkg::DEF_DATA_WIDTH;
    localparam int CMD_DEPTH     = qpbm_pkg::DEF_CMD_DEPTH;
    localparam int PENDING_DEPTH = qpbm_pkg::DEF_PENDING_DEPTH;
    localparam int RX_DEPTH      = qpbm_pkg::DEF_RX_DEPTH;
    localparam int RANDOM_BEATS  = 1450;
    localparam int PHASE_LEN     = 40;
    localparam int IDLE_PCT      = 37;
    localparam int STALL_LIMIT   = 2000;

    typedef logic [AW-1:0] addr_t;
    typedef logic [DW-1:0] word_t;

    typedef enum int {
        MIXED,
        BACKLOG,
        READ_FLOOD,
        NO_ACK,
        DRAIN
    } traffic_t;

    typedef struct packed {
        logic  cmd_valid;
        logic  cmd_write;
        addr_t cmd_addr;
        word_t cmd_wdata;
        logic  bus_ack;
        logic  bus_stall;
        word_t bus_rdata;
        logic  rx_pop;
    } beat_t;

    typedef struct packed {
        logic  bus_cyc;
        logic  bus_stb;
        logic  bus_we;
        addr_t bus_addr;
        word_t bus_wdata;
        logic  rx_valid;
        word_t rx_word;
        logic  cmd_dropped;
        logic  rx_dropped;
    } bus_out_t;

    typedef struct packed {
        logic  write;
        addr_t addr;
        word_t wdata;
    } cmd_entry_t;

    class bus_edge_scoreboard;
        cmd_entry_t cmd_fifo[$];
        bit         outstanding_we[$];
        word_t      rx_fifo[$];
        bit         cyc;
        bit         stb;
        bit         we;
        addr_t      addr;
        word_t      wdata;
        bus_out_t   outputs_due[$];
        int         errors;

        // Advances the bus master by one clock edge and queues its outputs.
        function void note_beat(beat_t b);
            bus_out_t   o;
            cmd_entry_t c;
            bit         kind;
            o = '0;
            if (b.rx_pop && rx_fifo.size() > 0)
                rx_fifo.delete(0);
            if (cyc && stb && !b.bus_stall && outstanding_we.size() < PENDING_DEPTH)
            begin
                outstanding_we.insert(outstanding_we.size(), we);
                stb = 0;
                we  = 0;
            end
            // A new command goes out only once the current strobe was taken.
            if (!stb && cmd_fifo.size() > 0 && outstanding_we.size() < PENDING_DEPTH)
            begin
                c = cmd_fifo[0];
                cmd_fifo.delete(0);
                cyc   = 1;
                stb   = 1;
                we    = c.write;
                addr  = c.addr;
                wdata = c.wdata;
            end
            if (cyc && b.bus_ack && outstanding_we.size() > 0)
            begin
                kind = outstanding_we[0];
                outstanding_we.delete(0);
                if (!kind)
                begin
                    if (rx_fifo.size() < RX_DEPTH)
                        rx_fifo.insert(rx_fifo.size(), b.bus_rdata);
                    else
                        o.rx_dropped = 1;
                end
            end
            if (cyc && outstanding_we.size() == 0 && !stb)
                cyc = 0;
            if (b.cmd_valid)
            begin
                if (cmd_fifo.size() < CMD_DEPTH)
                begin
                    c = {b.cmd_write, b.cmd_addr,
                         b.cmd_write ? b.cmd_wdata : word_t'(0)};
                    cmd_fifo.insert(cmd_fifo.size(), c);
                end
                else
                    o.cmd_dropped = 1;
            end
            o.bus_cyc   = cyc;
            o.bus_stb   = stb;
            o.bus_we    = stb ? we : 1'b0;
            o.bus_addr  = stb ? addr : addr_t'(0);
            o.bus_wdata = stb ? wdata : word_t'(0);
            o.rx_valid  = rx_fifo.size() > 0;
            o.rx_word   = rx_fifo.size() > 0 ? rx_fifo[0] : word_t'(0);
            outputs_due.insert(outputs_due.size(), o);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_outputs(bus_out_t got);
            bus_out_t want;
            if (outputs_due.size() == 0)
            begin
                $error("result beat with no expected outputs waiting");
                errors++;
                return;
            end
            want = outputs_due[0];
            outputs_due.delete(0);
            compare("bus_cyc", 64'(want.bus_cyc), 64'(got.bus_cyc));
            compare("bus_stb", 64'(want.bus_stb), 64'(got.bus_stb));
            compare("bus_we", 64'(want.bus_we), 64'(got.bus_we));
            compare("bus_addr", 64'(want.bus_addr), 64'(got.bus_addr));
            compare("bus_wdata", 64'(want.bus_wdata), 64'(got.bus_wdata));
            compare("rx_valid", 64'(want.rx_valid), 64'(got.rx_valid));
            compare("rx_word", 64'(want.rx_word), 64'(got.rx_word));
            compare("cmd_dropped", 64'(want.cmd_dropped), 64'(got.cmd_dropped));
            compare("rx_dropped", 64'(want.rx_dropped), 64'(got.rx_dropped));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   idle_cycles;

    qpbm_item_if   item_ch ();
    qpbm_result_if result_ch ();

    bus_edge_scoreboard scoreboard = new;

    queued_pipelined_bus_master_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic bit hit(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic word_t any_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t beat(logic cv, logic cw, addr_t a, word_t wd,
                                   logic ack, logic stall, word_t rd, logic pop);
        beat_t b;
        b = {cv, cw, a, wd, ack, stall, rd, pop};
        return b;
    endfunction

    // Presents one beat from a falling edge and returns at the falling edge
    // after it was taken.
    task automatic push_beat(beat_t b);
        while (!steady && hit(IDLE_PCT))
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.cmd_valid <= b.cmd_valid;
        item_ch.cmd_write <= b.cmd_write;
        item_ch.cmd_addr  <= b.cmd_addr;
        item_ch.cmd_wdata <= b.cmd_wdata;
        item_ch.bus_ack   <= b.bus_ack;
        item_ch.bus_stall <= b.bus_stall;
        item_ch.bus_rdata <= b.bus_rdata;
        item_ch.rx_pop    <= b.rx_pop;
        do
            @(posedge clk);
        while (!item_ch.ready);
        scoreboard.note_beat(b);
        @(negedge clk);
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= rst_n && (steady || !hit(IDLE_PCT));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            scoreboard.check_outputs({result_ch.bus_cyc, result_ch.bus_stb,
                                      result_ch.bus_we, result_ch.bus_addr,
                                      result_ch.bus_wdata, result_ch.rx_valid,
                                      result_ch.rx_word, result_ch.cmd_dropped,
                                      result_ch.rx_dropped});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("tb_queued_pipelined_bus_master_top: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        traffic_t mode;
        int       cmd_pct;
        int       write_pct;
        int       ack_pct;
        int       stall_pct;
        int       pop_pct;
        beat_t    b;

        rst_n             = 1'b0;
        steady            = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.cmd_valid = 1'b0;
        item_ch.cmd_write = 1'b0;
        item_ch.cmd_addr  = '0;
        item_ch.cmd_wdata = '0;
        item_ch.bus_ack   = 1'b0;
        item_ch.bus_stall = 1'b0;
        item_ch.bus_rdata = '0;
        item_ch.rx_pop    = 1'b0;
        mode              = MIXED;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stray acknowledge and a pop on an empty receive queue.
        push_beat(beat(1'b1, 1'b0, '0, '1, 1'b1, 1'b1, '1, 1'b1));
        // The read issues here while the write is queued behind it.
        push_beat(beat(1'b1, 1'b1, '1, '1, 1'b0, 1'b1, '0, 1'b0));
        // Strobe stalled: the write must wait.
        push_beat(beat(1'b0, 1'b0, '0, '0, 1'b0, 1'b1, '0, 1'b0));
        // Read taken and acknowledged on the same edge, write issued.
        push_beat(beat(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, '1, 1'b0));
        push_beat(beat(1'b0, 1'b0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        // Write retired with the pop; the cycle ends.
        push_beat(beat(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, '0, 1'b1));
        push_beat(beat(1'b0, 1'b0, '0, '0, 1'b1, 1'b0, 32'h5a5a_a5a5, 1'b0));
        // Overrun the command queue behind a stalled strobe.
        for (int i = 0; i < CMD_DEPTH + 2; i++)
            push_beat(beat(1'b1, i[0], addr_t'(i) << 28, ~(word_t'(i) << 4),
                           1'b0, 1'b1, '0, 1'b0));

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % PHASE_LEN == 0)
                mode = traffic_t'($urandom_range(4));
            steady = (i >= 500 && i < 800);
            case (mode)
                BACKLOG:    {cmd_pct, write_pct, ack_pct, stall_pct, pop_pct} =
                                {32'd90, 32'd50, 32'd30, 32'd85, 32'd30};
                READ_FLOOD: {cmd_pct, write_pct, ack_pct, stall_pct, pop_pct} =
                                {32'd60, 32'd10, 32'd85, 32'd10, 32'd3};
                NO_ACK:     {cmd_pct, write_pct, ack_pct, stall_pct, pop_pct} =
                                {32'd80, 32'd50, 32'd3, 32'd5, 32'd50};
                DRAIN:      {cmd_pct, write_pct, ack_pct, stall_pct, pop_pct} =
                                {32'd5, 32'd50, 32'd70, 32'd10, 32'd90};
                default:    {cmd_pct, write_pct, ack_pct, stall_pct, pop_pct} =
                                {32'd40, 32'd50, 32'd50, 32'd30, 32'd40};
            endcase
            b = beat(hit(cmd_pct), hit(write_pct), any_word(), any_word(),
                     hit(ack_pct), hit(stall_pct), any_word(), hit(pop_pct));
            push_beat(b);
        end
        steady = 1'b0;
        item_ch.valid <= 1'b0;

        while (scoreboard.outputs_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (scoreboard.errors == 0)
            $display("tb_queued_pipelined_bus_master_top: done, clean");
        else
            $display("tb_queued_pipelined_bus_master_top: done, errors");
        $finish;
    end

endmodule
